/* rtl/core/hct_pkg.sv */
// ----------------------------------------------------------------------------
// hct_pkg
// Shared constants, beat types and sequencer states of the homogeneous
// coordinate transform.
// ----------------------------------------------------------------------------
package hct_pkg;

    localparam int RANK      = 8;
    localparam int FRAC_BITS = 16;
    localparam int MAX_RANK  = 8;
    localparam int DIM       = RANK + 1;
    localparam int MAT_N     = DIM * DIM;
    localparam int ADDR_W    = $clog2(MAT_N);
    localparam int SUM_W     = $clog2(DIM);
    localparam int CRD_W     = (RANK > 1) ? $clog2(RANK) : 1;
    localparam int ACC_W     = 64;
    localparam int DIV_W     = ACC_W + FRAC_BITS;
    localparam int DIV_CW    = $clog2(DIV_W);
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] entry;
        logic signed [31:0] coord_0;
        logic signed [31:0] coord_1;
        logic signed [31:0] coord_2;
        logic signed [31:0] coord_3;
        logic signed [31:0] coord_4;
        logic signed [31:0] coord_5;
        logic signed [31:0] coord_6;
        logic signed [31:0] coord_7;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] mapped_0;
        logic signed [31:0] mapped_1;
        logic signed [31:0] mapped_2;
        logic signed [31:0] mapped_3;
        logic signed [31:0] mapped_4;
        logic signed [31:0] mapped_5;
        logic signed [31:0] mapped_6;
        logic signed [31:0] mapped_7;
        logic               divide_by_zero;
    } t_out_beat;

    typedef struct packed {
        logic     vld;
        t_in_beat beat;
    } t_q_head;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DSET,
        S_DIV,
        S_OUT
    } t_state;

endpackage

/* rtl/core/hct_ram.sv */
// ----------------------------------------------------------------------------
// hct_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/hct_front.sv */
// ----------------------------------------------------------------------------
// hct_front
// Accepts input beats, drops loads outside the matrix and queues the rest
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hct_front import hct_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_data,
    output logic     o_stall,
    output t_q_head  o_head,
    input  logic     i_pop
);

    t_in_beat   r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep, push;

    assign o_stall = (r_cnt == 2'd2);
    assign keep = (i_data.opcode == OP_XFORM) ||
                  ((32'(i_data.row) <= RANK) && (32'(i_data.col) <= RANK));
    assign push = i_valid && !o_stall && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_head.vld  = (r_cnt != 2'd0);
    assign o_head.beat = r_slot[r_rp];

endmodule

/* rtl/core/hct_back.sv */
// ----------------------------------------------------------------------------
// hct_back
// Executes queued beats: matrix writes, the multiply-accumulate sweep over
// the stored matrix, the per-element restoring divide and the result register.
// ----------------------------------------------------------------------------
module hct_back import hct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_beat o_data,
    input  logic      i_stall
);

    t_state r_state, n_state;

    logic                 pop, ram_we, issue, out_free, mac_done;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [31:0]          ram_rdata;
    logic [MAT_N-1:0]     r_mvld;

    logic [3:0]           r_i, r_j;
    logic                 r_iss_done;
    logic                 r_p1_vld, r_p1_ok, r_p1_diag, r_p1_first, r_p1_last;
    logic [3:0]           r_p1_i, r_p1_j;
    logic                 r_p2_vld, r_p2_first, r_p2_last;
    logic [3:0]           r_p2_j;
    logic signed [63:0]   r_prod, r_acc, acc_n, prod_n;
    logic signed [31:0]   m_val, c_val;
    logic signed [31:0]   r_coord [RANK];
    logic signed [31:0]   w_crd [MAX_RANK];
    logic [63:0]          r_sum [DIM];

    logic [CRD_W-1:0]     r_dj;
    logic [DIV_CW-1:0]    r_dbit;
    logic [DIV_W-1:0]     r_dvd;
    logic [63:0]          r_rem, r_dmag, num, den, nmag, dmag;
    logic [64:0]          rem2;
    logic                 ge, r_neg, r_big, big_n, r_dbz;
    logic [32:0]          r_q, q_n;
    logic [31:0]          quo;
    logic [31:0]          r_mapped [MAX_RANK];
    logic [31:0]          w_map [MAX_RANK];
    t_out_beat            r_out;
    logic                 r_out_vld;

    hct_ram #(.WIDTH(32), .DEPTH(MAT_N)) u_mat (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (i_head.beat.entry),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_vld || !i_stall;
    assign mac_done = r_iss_done && !r_p1_vld && !r_p2_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.vld && (i_head.beat.opcode == OP_XFORM)) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (mac_done) begin
                    n_state = (r_sum[RANK] == 64'd0) ? S_OUT : S_DSET;
                end
            end
            S_DSET: n_state = S_DIV;
            S_DIV: begin
                if (r_dbit == '0) begin
                    n_state = (32'(r_dj) == RANK - 1) ? S_OUT : S_DSET;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        pop    = (r_state == S_IDLE) && i_head.vld;
        ram_we = pop && (i_head.beat.opcode == OP_LOAD);
        issue  = (r_state == S_MAC) && !r_iss_done;
    end

    assign o_pop   = pop;
    assign wr_addr = ADDR_W'(32'(i_head.beat.row) * DIM + 32'(i_head.beat.col));
    assign rd_addr = ADDR_W'(32'(r_i) * DIM + 32'(r_j));

    assign w_crd[0] = i_head.beat.coord_0;
    assign w_crd[1] = i_head.beat.coord_1;
    assign w_crd[2] = i_head.beat.coord_2;
    assign w_crd[3] = i_head.beat.coord_3;
    assign w_crd[4] = i_head.beat.coord_4;
    assign w_crd[5] = i_head.beat.coord_5;
    assign w_crd[6] = i_head.beat.coord_6;
    assign w_crd[7] = i_head.beat.coord_7;

    always_comb begin
        m_val  = r_p1_ok ? signed'(ram_rdata) : (r_p1_diag ? signed'(ONE) : 32'sd0);
        c_val  = (32'(r_p1_i) == RANK) ? signed'(ONE) : r_coord[r_p1_i[CRD_W-1:0]];
        prod_n = c_val * m_val;
        acc_n  = (r_p2_first ? 64'sd0 : r_acc) + r_prod;
    end

    always_comb begin
        num  = r_sum[SUM_W'(r_dj)];
        den  = r_sum[RANK];
        nmag = num[63] ? (64'd0 - num) : num;
        dmag = den[63] ? (64'd0 - den) : den;
        rem2 = {r_rem, r_dvd[DIV_W-1]};
        ge   = (rem2 >= {1'b0, r_dmag});
        q_n  = {r_q[31:0], ge};
        big_n = r_big || r_q[32];
        if (r_neg) begin
            quo = (big_n || (q_n > 33'h080000000)) ? 32'h80000000 : (~q_n[31:0] + 32'd1);
        end else begin
            quo = (big_n || q_n[32] || q_n[31]) ? 32'h7FFFFFFF : q_n[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mvld     <= '0;
            r_iss_done <= 1'b0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_mvld[wr_addr] <= 1'b1;
            end
            if (pop) begin
                r_iss_done <= 1'b0;
            end else if (issue && (32'(r_i) == RANK) && (32'(r_j) == RANK)) begin
                r_iss_done <= 1'b1;
            end
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            if ((r_state == S_OUT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_i <= '0;
            r_j <= '0;
            for (int k = 0; k < RANK; k++) begin
                r_coord[k] <= w_crd[k];
            end
        end else if (issue) begin
            if (32'(r_i) == RANK) begin
                r_i <= '0;
                r_j <= r_j + 4'd1;
            end else begin
                r_i <= r_i + 4'd1;
            end
        end
        r_p1_i     <= r_i;
        r_p1_j     <= r_j;
        r_p1_ok    <= r_mvld[rd_addr];
        r_p1_diag  <= (r_i == r_j);
        r_p1_first <= (r_i == 4'd0);
        r_p1_last  <= (32'(r_i) == RANK);
        r_prod     <= prod_n;
        r_p2_j     <= r_p1_j;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        if (r_p2_vld) begin
            r_acc <= acc_n;
            if (r_p2_last) begin
                r_sum[r_p2_j[SUM_W-1:0]] <= 64'(acc_n);
            end
        end
        if ((r_state == S_MAC) && mac_done) begin
            r_dbz <= (r_sum[RANK] == 64'd0);
            r_dj  <= '0;
        end
        if (r_state == S_DSET) begin
            r_neg  <= num[63] ^ den[63];
            r_dmag <= dmag;
            r_dvd  <= DIV_W'(nmag) << FRAC_BITS;
            r_rem  <= '0;
            r_q    <= '0;
            r_big  <= 1'b0;
            r_dbit <= DIV_CW'(DIV_W - 1);
        end
        if (r_state == S_DIV) begin
            r_rem  <= ge ? 64'(rem2 - {1'b0, r_dmag}) : 64'(rem2);
            r_dvd  <= r_dvd << 1;
            r_q    <= q_n;
            r_big  <= big_n;
            r_dbit <= r_dbit - DIV_CW'(1);
            if (r_dbit == '0) begin
                r_mapped[r_dj] <= quo;
                r_dj <= r_dj + CRD_W'(1);
            end
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out.mapped_0       <= w_map[0];
            r_out.mapped_1       <= w_map[1];
            r_out.mapped_2       <= w_map[2];
            r_out.mapped_3       <= w_map[3];
            r_out.mapped_4       <= w_map[4];
            r_out.mapped_5       <= w_map[5];
            r_out.mapped_6       <= w_map[6];
            r_out.mapped_7       <= w_map[7];
            r_out.divide_by_zero <= r_dbz;
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_RANK; k++) begin
            w_map[k] = ((k < RANK) && !r_dbz) ? r_mapped[k] : 32'd0;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

`ifndef SYNTH
    a_ram_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("Matrix write outside the idle state.");
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_OUT))
        else $error("Result beat raised without the output state.");
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.divide_by_zero) |-> (o_data.mapped_0 == 32'sd0))
        else $error("Zero divisor result carries a nonzero element.");
    a_mac_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSET) |-> (!r_p1_vld && !r_p2_vld))
        else $error("Divide started before the accumulate pipeline drained.");
`endif

endmodule

/* rtl/core/homogeneous_coordinate_transform.sv */
// ----------------------------------------------------------------------------
// homogeneous_coordinate_transform
// Maps a signed fixed-point coordinate through a stored homogeneous matrix
// and divides by the homogeneous sum.
// ----------------------------------------------------------------------------
// A load beat writes one matrix entry as it leaves the input queue; it gives
// no result. A transform beat runs the multiply-accumulate sweep, one product
// per cycle over the 81 matrix entries read from the single RAM port, then
// divides each mapped element in the one-bit-per-cycle restoring divider and
// finally loads the result register. A zero divisor skips the divides. The
// matrix holds identity after reset through per-entry valid bits, with no
// clearing pass.
module homogeneous_coordinate_transform import hct_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_beat o_data,
    input  logic      i_stall
);

    t_q_head head;
    logic    pop;

    hct_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_head  (head),
        .i_pop   (pop)
    );

    hct_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
